>>> rtl/ieel_pkg.sv
// Package for the indexed insert/erase list: sizes, command codes, internal op
// kinds and the command/status structs between controller and datapath.
// No dependencies; every other file in rtl uses it by scoped names.
package ieel_pkg;

	// Store geometry
	localparam int DEPTH      = 64;
	localparam int DATA_WIDTH = 32;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int POS_W      = 7;
	localparam int CMD_W      = 3;

	// Stream payload widths, whole bytes
	localparam int IN_FIELDS_W  = CMD_W + POS_W + DATA_WIDTH;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 1 + DATA_WIDTH + CNT_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Command codes on the input stream
	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT_AT = 3'd0,
		CMD_ERASE_AT  = 3'd1,
		CMD_READ_AT   = 3'd2,
		CMD_CLEAR     = 3'd3,
		CMD_PUSH_BACK = 3'd4,
		CMD_POP_BACK  = 3'd5,
		CMD_READ_BACK = 3'd6
	} cmd_t;

	// Normalized operation after position resolution
	typedef enum logic [2:0] {
		OP_NONE = 3'd0,
		OP_INS  = 3'd1,
		OP_ERA  = 3'd2,
		OP_RD   = 3'd3,
		OP_CLR  = 3'd4
	} op_t;

	// Controller to datapath
	typedef struct packed {
		logic load;      // capture the accepted transaction
		logic start_up;  // cursor to count-1 for an upward shift
		logic start_dn;  // cursor to position+1 for a downward shift
		logic move;      // read at cursor, queue write one step over, step cursor
		logic dir_up;    // direction of the current move
		logic rd_issue;  // read the entry at position
		logic store;     // write the word at position, count up
		logic dec;       // count down
		logic clear;     // count to zero
		logic finish;    // load the result register
		logic res_ok;    // result status
		logic res_rd;    // result carries the word read
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic ins_ok;      // position <= count and room left
		logic idx_ok;      // position < count
		logic at_end;      // position == count
		logic at_last;     // position + 1 == count
		logic cur_at_pos;  // upward shift reached the position
		logic cur_at_last; // downward shift reached the last entry
		logic out_free;    // result register can take a result
	} ctrl_status_t;

endpackage

>>> rtl/ieel_datapath.sv
// Datapath of the indexed insert/erase list: entry memory, fill count, shift
// cursor with a one-deep move pipeline, and the result register.
// Depends on ieel_pkg; driven by ieel_ctrl through ctrl_cmd_t.
module ieel_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [ieel_pkg::CMD_W-1:0]          cmd_in,
	input  logic [ieel_pkg::POS_W-1:0]          position,
	input  logic [ieel_pkg::DATA_WIDTH-1:0]     word_in,
	input  ieel_pkg::ctrl_cmd_t                 ctl,
	output ieel_pkg::ctrl_status_t              status,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                ok,
	output logic [ieel_pkg::DATA_WIDTH-1:0]     word_out,
	output logic [ieel_pkg::CNT_W-1:0]          fill_count,
	output logic                                is_empty
);

	logic [ieel_pkg::DATA_WIDTH-1:0] mem [ieel_pkg::DEPTH];

	ieel_pkg::op_t                   op_q;
	logic [ieel_pkg::POS_W-1:0]      pos_q;
	logic [ieel_pkg::DATA_WIDTH-1:0] word_q;
	logic [ieel_pkg::CNT_W-1:0]      count_q;
	logic [ieel_pkg::ADDR_W-1:0]     cur_q;
	logic                            mv_valid_s1;
	logic [ieel_pkg::ADDR_W-1:0]     mv_dst_s1;
	logic [ieel_pkg::DATA_WIDTH-1:0] rdata_s1;
	logic                            out_valid_q;
	logic                            ok_q;
	logic [ieel_pkg::DATA_WIDTH-1:0] word_out_q;
	logic [ieel_pkg::CNT_W-1:0]      fill_q;
	logic                            empty_q;

	logic [ieel_pkg::POS_W-1:0]      cnt_as_pos;
	logic [ieel_pkg::ADDR_W-1:0]     pos_a;
	logic [ieel_pkg::ADDR_W-1:0]     rd_addr;
	logic                            rd_en;
	ieel_pkg::op_t                   op_d;
	logic [ieel_pkg::POS_W-1:0]      pos_d;

	assign cnt_as_pos = ieel_pkg::POS_W'(count_q);
	assign pos_a      = pos_q[ieel_pkg::ADDR_W-1:0];

	// Resolve back-of-list commands to a position
	always_comb begin
		op_d  = ieel_pkg::OP_NONE;
		pos_d = position;
		unique case (ieel_pkg::cmd_t'(cmd_in))
			ieel_pkg::CMD_INSERT_AT: begin
				op_d = ieel_pkg::OP_INS;
			end
			ieel_pkg::CMD_PUSH_BACK: begin
				op_d  = ieel_pkg::OP_INS;
				pos_d = cnt_as_pos;
			end
			ieel_pkg::CMD_ERASE_AT: begin
				op_d = ieel_pkg::OP_ERA;
			end
			ieel_pkg::CMD_POP_BACK: begin
				op_d  = ieel_pkg::OP_ERA;
				pos_d = cnt_as_pos - ieel_pkg::POS_W'(1);
			end
			ieel_pkg::CMD_READ_AT: begin
				op_d = ieel_pkg::OP_RD;
			end
			ieel_pkg::CMD_READ_BACK: begin
				op_d  = ieel_pkg::OP_RD;
				pos_d = cnt_as_pos - ieel_pkg::POS_W'(1);
			end
			ieel_pkg::CMD_CLEAR: begin
				op_d = ieel_pkg::OP_CLR;
			end
			default: begin
				op_d = ieel_pkg::OP_NONE;
			end
		endcase
	end

	// Hold the transaction being worked on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= ieel_pkg::OP_NONE;
		end else if (ctl.load) begin
			op_q <= op_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			pos_q  <= pos_d;
			word_q <= word_in;
		end
	end

	// Fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctl.clear) begin
			count_q <= '0;
		end else if (ctl.store) begin
			count_q <= count_q + ieel_pkg::CNT_W'(1);
		end else if (ctl.dec) begin
			count_q <= count_q - ieel_pkg::CNT_W'(1);
		end
	end

	// Shift cursor
	always_ff @(posedge clk) begin
		if (ctl.start_up) begin
			cur_q <= ieel_pkg::ADDR_W'(count_q - ieel_pkg::CNT_W'(1));
		end else if (ctl.start_dn) begin
			cur_q <= ieel_pkg::ADDR_W'(pos_q + ieel_pkg::POS_W'(1));
		end else if (ctl.move) begin
			cur_q <= ctl.dir_up ? cur_q - ieel_pkg::ADDR_W'(1)
			                    : cur_q + ieel_pkg::ADDR_W'(1);
		end
	end

	// Queue the write half of each move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_valid_s1 <= 1'b0;
		end else begin
			mv_valid_s1 <= ctl.move;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.move) begin
			mv_dst_s1 <= ctl.dir_up ? cur_q + ieel_pkg::ADDR_W'(1)
			                        : cur_q - ieel_pkg::ADDR_W'(1);
		end
	end

	// Entry memory: one write, one registered read per cycle
	assign rd_en   = ctl.move | ctl.rd_issue;
	assign rd_addr = ctl.move ? cur_q : pos_a;

	always_ff @(posedge clk) begin
		if (mv_valid_s1) begin
			mem[mv_dst_s1] <= rdata_s1;
		end else if (ctl.store) begin
			mem[pos_a] <= word_q;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			ok_q       <= ctl.res_ok;
			word_out_q <= (ctl.res_ok && ctl.res_rd) ? rdata_s1 : '0;
			fill_q     <= count_q;
			empty_q    <= (count_q == '0);
		end
	end

	// Status back to the controller
	always_comb begin
		status.op          = op_q;
		status.ins_ok      = (pos_q <= cnt_as_pos) &&
		                     (count_q != ieel_pkg::CNT_W'(ieel_pkg::DEPTH));
		status.idx_ok      = (pos_q < cnt_as_pos);
		status.at_end      = (pos_q == cnt_as_pos);
		status.at_last     = ((pos_q + ieel_pkg::POS_W'(1)) == cnt_as_pos);
		status.cur_at_pos  = (cur_q == pos_a);
		status.cur_at_last = ((ieel_pkg::CNT_W'(cur_q) + ieel_pkg::CNT_W'(1)) == count_q);
		status.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign ok         = ok_q;
	assign word_out   = word_out_q;
	assign fill_count = fill_q;
	assign is_empty   = empty_q;

endmodule

>>> rtl/ieel_ctrl.sv
// Controller of the indexed insert/erase list: one-hot state machine that
// sequences decode, entry shifts, the final store and the result hand-off.
// Depends on ieel_pkg; talks to ieel_datapath only through the command/status structs.
module ieel_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  ieel_pkg::ctrl_status_t status,
	output ieel_pkg::ctrl_cmd_t    ctl
);

	typedef enum logic [7:0] {
		ST_IDLE     = 8'b0000_0001,
		ST_DECODE   = 8'b0000_0010,
		ST_SHIFT_UP = 8'b0000_0100,
		ST_DRAIN_UP = 8'b0000_1000,
		ST_STORE    = 8'b0001_0000,
		ST_SHIFT_DN = 8'b0010_0000,
		ST_DRAIN_DN = 8'b0100_0000,
		ST_FINISH   = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   ok_q, ok_d;
	logic   rd_q, rd_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ok_q    <= 1'b0;
			rd_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
			rd_q    <= rd_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		rd_d    = rd_q;
		ctl     = '0;
		ctl.res_ok = ok_q;
		ctl.res_rd = rd_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				ok_d    = 1'b0;
				rd_d    = 1'b0;
				state_d = ST_FINISH;
				unique case (status.op)
					ieel_pkg::OP_INS: begin
						if (status.ins_ok) begin
							ok_d = 1'b1;
							if (status.at_end) begin
								state_d = ST_STORE;
							end else begin
								ctl.start_up = 1'b1;
								state_d      = ST_SHIFT_UP;
							end
						end
					end
					ieel_pkg::OP_ERA: begin
						if (status.idx_ok) begin
							ok_d = 1'b1;
							if (status.at_last) begin
								ctl.dec = 1'b1;
							end else begin
								ctl.start_dn = 1'b1;
								state_d      = ST_SHIFT_DN;
							end
						end
					end
					ieel_pkg::OP_RD: begin
						if (status.idx_ok) begin
							ok_d         = 1'b1;
							rd_d         = 1'b1;
							ctl.rd_issue = 1'b1;
						end
					end
					ieel_pkg::OP_CLR: begin
						ok_d      = 1'b1;
						ctl.clear = 1'b1;
					end
					default: begin
						ok_d = 1'b0;
					end
				endcase
			end
			// Move entries up one place, from the back down to the position
			ST_SHIFT_UP: begin
				ctl.move   = 1'b1;
				ctl.dir_up = 1'b1;
				if (status.cur_at_pos) begin
					state_d = ST_DRAIN_UP;
				end
			end
			// Let the last queued move land before the store
			ST_DRAIN_UP: begin
				state_d = ST_STORE;
			end
			ST_STORE: begin
				ctl.store = 1'b1;
				state_d   = ST_FINISH;
			end
			// Move entries down one place, from position+1 to the back
			ST_SHIFT_DN: begin
				ctl.move = 1'b1;
				if (status.cur_at_last) begin
					state_d = ST_DRAIN_DN;
				end
			end
			ST_DRAIN_DN: begin
				ctl.dec = 1'b1;
				state_d = ST_FINISH;
			end
			// Hand the result over once the result register is free
			ST_FINISH: begin
				if (status.out_free) begin
					ctl.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/indexed_insert_erase_list_core.sv
// Indexed insert/erase list: an ordered list of up to 64 words of 32 bits in a
// single-port-write, registered-read memory with a fill count. Each transaction
// gives exactly one result transaction. Reads, clear, rejected commands and
// erase or pop of the last entry go from decode straight to the result
// hand-off; an insert at the end of the list (push_back) adds a store step,
// an insert at position p below the count n first moves the entries from
// n-1 down to p up one place and then stores, and an erase at p moves the
// entries behind p down one place. Entries move one per cycle through the
// memory's one read and one write port. A new transaction is taken the cycle
// after the previous result is loaded into the output register, even while
// that result still waits on tready. No clearing pass runs after reset.
module indexed_insert_erase_list_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [2:0] cmd, [9:3] position, [41:10] word_in, upper bits zero
	input  logic [ieel_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] ok, [32:1] word_out, [39:33] fill_count, [40] is_empty, upper bits zero
	output logic [ieel_pkg::OUT_TDATA_W-1:0]   m_tdata
);

	localparam int POS_LO  = ieel_pkg::CMD_W;
	localparam int WORD_LO = ieel_pkg::CMD_W + ieel_pkg::POS_W;
	localparam int FILL_LO = 1 + ieel_pkg::DATA_WIDTH;

	ieel_pkg::ctrl_cmd_t             ctl;
	ieel_pkg::ctrl_status_t          status;
	logic                            ok;
	logic [ieel_pkg::DATA_WIDTH-1:0] word_out;
	logic [ieel_pkg::CNT_W-1:0]      fill_count;
	logic                            is_empty;

	ieel_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.ctl      (ctl)
	);

	ieel_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_in     (s_tdata[ieel_pkg::CMD_W-1:0]),
		.position   (s_tdata[POS_LO +: ieel_pkg::POS_W]),
		.word_in    (s_tdata[WORD_LO +: ieel_pkg::DATA_WIDTH]),
		.ctl        (ctl),
		.status     (status),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.ok         (ok),
		.word_out   (word_out),
		.fill_count (fill_count),
		.is_empty   (is_empty)
	);

	// Pack the result fields, lowest first
	always_comb begin
		m_tdata = '0;
		m_tdata[0]                                = ok;
		m_tdata[1 +: ieel_pkg::DATA_WIDTH]        = word_out;
		m_tdata[FILL_LO +: ieel_pkg::CNT_W]       = fill_count;
		m_tdata[FILL_LO + ieel_pkg::CNT_W]        = is_empty;
	end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for indexed_insert_erase_list_core: directed table,
// then shaped random command bursts, checked against an in-bench list model.
// Depends on rtl/ieel_pkg.sv and rtl/indexed_insert_erase_list_core.sv.
module tb_top;

	localparam logic [2:0] CMD_UNUSED  = 3'd7;
	localparam int         RAND_ITEMS  = 700;
	localparam int         HOLD_CYCLES = 400;
	localparam int         DRAIN_LIMIT = 20000;
	localparam int         TAIL_CYCLES = 100;

	// One result transaction as the list reports it
	typedef struct packed {
		logic        ok;
		logic [31:0] word;
		logic [6:0]  fill;
		logic        empty;
	} list_status_t;

	// Directed stimulus row; want is used only when typed is set
	typedef struct {
		logic [2:0]   cmd;
		logic [6:0]   pos;
		logic [31:0]  word;
		bit           typed;
		list_status_t want;
	} stim_row_t;

	typedef enum {FILL_UP, GROW, SHRINK, MIXED, NOISE} burst_mode_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [ieel_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [ieel_pkg::OUT_TDATA_W-1:0] m_tdata;

	// Shadow copy of the list
	logic [ieel_pkg::DATA_WIDTH-1:0] list_mem [ieel_pkg::DEPTH];
	logic [6:0]                      list_len;

	list_status_t expected_status_q [$];
	stim_row_t    stim_table [$];
	int           mismatch_cnt;
	int           cmd_seen [8];
	int           reject_cnt;
	int           full_reject_cnt;
	int           peak_fill;
	bit           hold_req;

	indexed_insert_erase_list_core DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	// Free-running clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop if the run hangs
	initial begin
		#(5_000_000);
		$display("[indexed_insert_erase_list_core] ERROR");
		$finish;
	end

	task automatic note_mismatch(input string msg);
		mismatch_cnt++;
		$display("%0t mismatch: %s", $time, msg);
	endtask

	// Open a slot at pos, moving later entries up
	function automatic bit shift_in(input logic [6:0] pos, input logic [31:0] w);
		int k;
		if (pos > list_len || list_len >= ieel_pkg::DEPTH) begin
			return 1'b0;
		end
		for (k = list_len; k > pos; k--) begin
			list_mem[k] = list_mem[k-1];
		end
		list_mem[pos] = w;
		list_len++;
		return 1'b1;
	endfunction

	// Close the slot at pos, moving later entries down
	function automatic bit shift_out(input logic [6:0] pos);
		int k;
		if (pos >= list_len) begin
			return 1'b0;
		end
		for (k = pos; k + 1 < list_len; k++) begin
			list_mem[k] = list_mem[k+1];
		end
		list_len--;
		return 1'b1;
	endfunction

	// Apply one command to the shadow list and return its status
	function automatic list_status_t apply_list_cmd(input logic [2:0] c, input logic [6:0] p,
			input logic [31:0] w);
		list_status_t res;
		res = '0;
		case (c)
			ieel_pkg::CMD_INSERT_AT: begin
				res.ok = shift_in(p, w);
			end
			ieel_pkg::CMD_ERASE_AT: begin
				res.ok = shift_out(p);
			end
			ieel_pkg::CMD_READ_AT: begin
				if (p < list_len) begin
					res.ok   = 1'b1;
					res.word = list_mem[p];
				end
			end
			ieel_pkg::CMD_CLEAR: begin
				list_len = '0;
				res.ok   = 1'b1;
			end
			ieel_pkg::CMD_PUSH_BACK: begin
				res.ok = shift_in(list_len, w);
			end
			ieel_pkg::CMD_POP_BACK: begin
				if (list_len > 0) begin
					res.ok = shift_out(list_len - 7'd1);
				end
			end
			ieel_pkg::CMD_READ_BACK: begin
				if (list_len > 0) begin
					res.ok   = 1'b1;
					res.word = list_mem[list_len - 7'd1];
				end
			end
			default: begin
				res.ok = 1'b0;
			end
		endcase
		res.fill  = list_len;
		res.empty = (list_len == 0);
		return res;
	endfunction

	// Mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void table_row(input logic [2:0] c, input logic [6:0] p,
			input logic [31:0] w, input bit typed, input logic ok, input logic [31:0] rd,
			input logic [6:0] fill, input logic empty);
		stim_row_t row;
		row.cmd   = c;
		row.pos   = p;
		row.word  = w;
		row.typed = typed;
		row.want  = '{ok: ok, word: rd, fill: fill, empty: empty};
		stim_table.push_back(row);
	endfunction

	// Offer one command, hold it until accepted, then record what it should return
	task automatic offer_cmd(input logic [2:0] c, input logic [6:0] p, input logic [31:0] w,
			input bit typed, input list_status_t want);
		list_status_t pred;
		bit           was_full;
		s_tvalid <= 1'b1;
		s_tdata  <= {{(ieel_pkg::IN_TDATA_W - 42){1'b0}}, w, p, c};
		do begin
			@(posedge clk);
		end while (!s_tready);
		was_full = (list_len == ieel_pkg::DEPTH);
		pred     = apply_list_cmd(c, p, w);
		expected_status_q.push_back(typed ? want : pred);
		cmd_seen[c]++;
		if (!pred.ok) begin
			reject_cnt++;
			if (was_full && (c == ieel_pkg::CMD_INSERT_AT || c == ieel_pkg::CMD_PUSH_BACK)) begin
				full_reject_cnt++;
			end
		end
		if (pred.fill > peak_fill) begin
			peak_fill = pred.fill;
		end
	endtask

	task automatic idle_sender(input int unsigned cycles);
		if (cycles > 0) begin
			s_tvalid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Stop offering until every outstanding result has come back
	task automatic drain_results();
		if (expected_status_q.size() != 0) begin
			s_tvalid <= 1'b0;
			while (expected_status_q.size() != 0) begin
				@(posedge clk);
			end
		end
	endtask

	// Receiver: random back-pressure, calm stretches, one long hold-off on request
	initial begin : drive_ready
		int unsigned stall;
		int unsigned calm_left;
		m_tready  = 1'b0;
		calm_left = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				stall    = HOLD_CYCLES;
				hold_req = 1'b0;
			end else if (calm_left > 0) begin
				stall = 0;
				calm_left--;
			end else begin
				stall = pick_gap();
				if ($urandom_range(0, 59) == 0) begin
					calm_left = $urandom_range(40, 160);
				end
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
		end
	end

	// Compare every result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		list_status_t want;
		list_status_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.ok    = m_tdata[0];
			got.word  = m_tdata[32:1];
			got.fill  = m_tdata[39:33];
			got.empty = m_tdata[40];
			if (expected_status_q.size() == 0) begin
				note_mismatch($sformatf("result with nothing outstanding, tdata %h", m_tdata));
			end else begin
				want = expected_status_q.pop_front();
				if (got.ok !== want.ok) begin
					note_mismatch($sformatf("ok got %b want %b", got.ok, want.ok));
				end
				if (got.word !== want.word) begin
					note_mismatch($sformatf("word_out got %h want %h", got.word, want.word));
				end
				if (got.fill !== want.fill) begin
					note_mismatch($sformatf("fill_count got %0d want %0d", got.fill, want.fill));
				end
				if (got.empty !== want.empty) begin
					note_mismatch($sformatf("is_empty got %b want %b", got.empty, want.empty));
				end
			end
		end
	end

	// Sender: reset, directed table, shaped random bursts, final drain
	initial begin : drive_commands
		list_status_t no_want;
		burst_mode_t  mode;
		int           cmd_weight [8];
		int           n;
		int           b;
		int           burst;
		int           total;
		int           r;
		int           k;
		int           waited;
		bit           calm;
		logic [2:0]   c;
		logic [6:0]   p;
		logic [31:0]  w;

		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		hold_req     = 1'b0;
		mismatch_cnt = 0;
		reject_cnt   = 0;
		peak_fill    = 0;
		full_reject_cnt = 0;
		list_len     = '0;
		no_want      = '0;
		foreach (cmd_seen[i]) cmd_seen[i] = 0;
		foreach (list_mem[i]) list_mem[i] = '0;

		// Rejects on an empty list, first entries, middle and end inserts,
		// out-of-range positions, the unused code and clear
		table_row(ieel_pkg::CMD_READ_BACK, 7'd0,   32'h0,        1, 0, 32'h0,        0, 1);
		table_row(ieel_pkg::CMD_POP_BACK,  7'd0,   32'h0,        1, 0, 32'h0,        0, 1);
		table_row(ieel_pkg::CMD_ERASE_AT,  7'd0,   32'h0,        1, 0, 32'h0,        0, 1);
		table_row(ieel_pkg::CMD_READ_AT,   7'd0,   32'h0,        1, 0, 32'h0,        0, 1);
		table_row(ieel_pkg::CMD_INSERT_AT, 7'd1,   32'h12345678, 1, 0, 32'h0,        0, 1);
		table_row(CMD_UNUSED,              7'd127, 32'hFFFFFFFF, 1, 0, 32'h0,        0, 1);
		table_row(ieel_pkg::CMD_INSERT_AT, 7'd0,   32'hFFFFFFFF, 1, 1, 32'h0,        1, 0);
		table_row(ieel_pkg::CMD_PUSH_BACK, 7'd0,   32'h0,        1, 1, 32'h0,        2, 0);
		table_row(ieel_pkg::CMD_INSERT_AT, 7'd1,   32'hA5A5A5A5, 0, 0, 32'h0,        0, 0);
		table_row(ieel_pkg::CMD_INSERT_AT, 7'd3,   32'h5A5A5A5A, 0, 0, 32'h0,        0, 0);
		table_row(ieel_pkg::CMD_INSERT_AT, 7'd0,   32'h00000001, 0, 0, 32'h0,        0, 0);
		table_row(ieel_pkg::CMD_READ_AT,   7'd1,   32'h0,        1, 1, 32'hFFFFFFFF, 5, 0);
		table_row(ieel_pkg::CMD_READ_AT,   7'd127, 32'h0,        1, 0, 32'h0,        5, 0);
		table_row(ieel_pkg::CMD_READ_AT,   7'd5,   32'h0,        1, 0, 32'h0,        5, 0);
		table_row(ieel_pkg::CMD_READ_BACK, 7'd0,   32'h0,        0, 0, 32'h0,        0, 0);
		table_row(ieel_pkg::CMD_ERASE_AT,  7'd0,   32'h0,        0, 0, 32'h0,        0, 0);
		table_row(ieel_pkg::CMD_ERASE_AT,  7'd64,  32'h0,        1, 0, 32'h0,        4, 0);
		table_row(ieel_pkg::CMD_ERASE_AT,  7'd4,   32'h0,        1, 0, 32'h0,        4, 0);
		table_row(ieel_pkg::CMD_ERASE_AT,  7'd3,   32'h0,        0, 0, 32'h0,        0, 0);
		table_row(CMD_UNUSED,              7'd0,   32'h0,        1, 0, 32'h0,        3, 0);
		table_row(ieel_pkg::CMD_POP_BACK,  7'd0,   32'h0,        0, 0, 32'h0,        0, 0);
		table_row(ieel_pkg::CMD_READ_AT,   7'd0,   32'h0,        1, 1, 32'hFFFFFFFF, 2, 0);
		table_row(ieel_pkg::CMD_CLEAR,     7'd0,   32'h0,        1, 1, 32'h0,        0, 1);
		table_row(ieel_pkg::CMD_READ_BACK, 7'd0,   32'h0,        1, 0, 32'h0,        0, 1);
		table_row(ieel_pkg::CMD_CLEAR,     7'd0,   32'h0,        1, 1, 32'h0,        0, 1);

		// Hold reset, then release on a clock edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (stim_table[i]) begin
			offer_cmd(stim_table[i].cmd, stim_table[i].pos, stim_table[i].word,
				stim_table[i].typed, stim_table[i].want);
			idle_sender(pick_gap());
		end
		drain_results();

		// Random bursts; the first one fills the list to overflow
		n = 0;
		total = 0;
		while (n < RAND_ITEMS) begin
			if (total == 0) begin
				mode  = FILL_UP;
				burst = 72;
			end else begin
				r     = $urandom_range(0, 9);
				mode  = (r < 3) ? GROW : (r < 6) ? SHRINK : (r < 9) ? MIXED : NOISE;
				burst = $urandom_range(20, 60);
			end
			total++;
			calm = ($urandom_range(0, 3) == 0);
			foreach (cmd_weight[i]) cmd_weight[i] = 1;
			case (mode)
				FILL_UP: begin
					foreach (cmd_weight[i]) cmd_weight[i] = 0;
					cmd_weight[ieel_pkg::CMD_INSERT_AT] = 40;
					cmd_weight[ieel_pkg::CMD_PUSH_BACK] = 60;
				end
				GROW: begin
					cmd_weight[ieel_pkg::CMD_INSERT_AT] = 35;
					cmd_weight[ieel_pkg::CMD_ERASE_AT]  = 8;
					cmd_weight[ieel_pkg::CMD_READ_AT]   = 12;
					cmd_weight[ieel_pkg::CMD_CLEAR]     = 0;
					cmd_weight[ieel_pkg::CMD_PUSH_BACK] = 25;
					cmd_weight[ieel_pkg::CMD_POP_BACK]  = 7;
					cmd_weight[ieel_pkg::CMD_READ_BACK] = 10;
					cmd_weight[CMD_UNUSED]              = 3;
				end
				SHRINK: begin
					cmd_weight[ieel_pkg::CMD_INSERT_AT] = 8;
					cmd_weight[ieel_pkg::CMD_ERASE_AT]  = 35;
					cmd_weight[ieel_pkg::CMD_READ_AT]   = 12;
					cmd_weight[ieel_pkg::CMD_CLEAR]     = 1;
					cmd_weight[ieel_pkg::CMD_PUSH_BACK] = 7;
					cmd_weight[ieel_pkg::CMD_POP_BACK]  = 25;
					cmd_weight[ieel_pkg::CMD_READ_BACK] = 10;
					cmd_weight[CMD_UNUSED]              = 2;
				end
				MIXED: begin
					cmd_weight[ieel_pkg::CMD_INSERT_AT] = 20;
					cmd_weight[ieel_pkg::CMD_ERASE_AT]  = 20;
					cmd_weight[ieel_pkg::CMD_READ_AT]   = 15;
					cmd_weight[ieel_pkg::CMD_CLEAR]     = 2;
					cmd_weight[ieel_pkg::CMD_PUSH_BACK] = 15;
					cmd_weight[ieel_pkg::CMD_POP_BACK]  = 13;
					cmd_weight[ieel_pkg::CMD_READ_BACK] = 13;
					cmd_weight[CMD_UNUSED]              = 2;
				end
				default: begin
				end
			endcase

			for (b = 0; b < burst && n < RAND_ITEMS; b++) begin
				// Long receiver hold-off while commands keep coming
				if (n == RAND_ITEMS * 3 / 7) begin
					hold_req = 1'b1;
					calm     = 1'b1;
				end
				// Pause until every result is back
				if (n == RAND_ITEMS * 5 / 7) begin
					drain_results();
				end

				// Weighted command choice
				r = 0;
				foreach (cmd_weight[i]) r += cmd_weight[i];
				r = $urandom_range(0, r - 1);
				c = CMD_UNUSED;
				for (k = 0; k < 8; k++) begin
					if (r < cmd_weight[k]) begin
						c = 3'(k);
						break;
					end
					r -= cmd_weight[k];
				end

				// Position: mostly in range, sometimes past the end, anywhere in noise
				r = $urandom_range(0, 99);
				if (mode == NOISE) begin
					p = 7'($urandom_range(0, 127));
				end else if (c == ieel_pkg::CMD_INSERT_AT) begin
					p = (r < 85) ? 7'($urandom_range(0, list_len)) :
						7'($urandom_range(list_len + 1, 127));
				end else if (list_len > 0 && r < 85) begin
					p = 7'($urandom_range(0, list_len - 1));
				end else begin
					p = 7'($urandom_range(list_len, 127));
				end

				r = $urandom_range(0, 19);
				w = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFFFFFF : $urandom();

				offer_cmd(c, p, w, 1'b0, no_want);
				n++;
				idle_sender(calm ? 0 : pick_gap());
			end
		end

		// Wait out every outstanding result, then a quiet tail
		s_tvalid <= 1'b0;
		waited = 0;
		while (expected_status_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_status_q.size() != 0) begin
			note_mismatch($sformatf("%0d results never arrived", expected_status_q.size()));
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d directed + %0d random commands, %0d rejected, %0d on a full list",
			stim_table.size(), RAND_ITEMS, reject_cnt, full_reject_cnt);
		$display("run: peak fill %0d, ins %0d era %0d rd %0d clr %0d push %0d pop %0d rdb %0d bad %0d",
			peak_fill, cmd_seen[ieel_pkg::CMD_INSERT_AT], cmd_seen[ieel_pkg::CMD_ERASE_AT],
			cmd_seen[ieel_pkg::CMD_READ_AT], cmd_seen[ieel_pkg::CMD_CLEAR],
			cmd_seen[ieel_pkg::CMD_PUSH_BACK], cmd_seen[ieel_pkg::CMD_POP_BACK],
			cmd_seen[ieel_pkg::CMD_READ_BACK], cmd_seen[CMD_UNUSED]);
		if (mismatch_cnt == 0) begin
			$display("[indexed_insert_erase_list_core] OK");
		end else begin
			$display("[indexed_insert_erase_list_core] ERROR");
		end
		$finish;
	end

endmodule
